// ----- src/swva_pkg.sv -----
// Shared types and constants for the sliding window vector average unit.
package swva_pkg;

    localparam int LANES        = 8;
    localparam int RING_DEPTH   = 128;
    localparam int FIELD_LANES  = 8;
    localparam int SAMPLE_W     = 16;
    localparam int WIN_W        = 8;
    localparam int FILL_W       = 8;
    localparam int SLOT_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LEN_W        = $clog2(RING_DEPTH + 1);
    localparam int CMP_W        = (LEN_W > WIN_W) ? LEN_W : WIN_W;
    localparam int TOT_W        = SAMPLE_W + SLOT_W;
    localparam int STEP_W       = $clog2(TOT_W);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(100);

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample sample_7;
        t_sample sample_6;
        t_sample sample_5;
        t_sample sample_4;
        t_sample sample_3;
        t_sample sample_2;
        t_sample sample_1;
        t_sample sample_0;
    } t_in_beat;

    typedef struct packed {
        logic [FILL_W-1:0] fill_count;
        t_sample           mean_7;
        t_sample           mean_6;
        t_sample           mean_5;
        t_sample           mean_4;
        t_sample           mean_3;
        t_sample           mean_2;
        t_sample           mean_1;
        t_sample           mean_0;
    } t_out_beat;

    typedef struct packed {
        t_sample [LANES-1:0] samples;
        logic [SLOT_W-1:0]   slot;
        logic                full;
        logic [LEN_W-1:0]    count;
    } t_job;

endpackage

// ----- src/sliding_window_vector_average_unit.sv -----
// Top level of the sliding window vector average unit.
// A beat passes the job queue; the back end then reads, sums, prepares, runs 23 divider steps and hands off.
// The back end works on one beat at a time and takes no new job until its result is handed off.
// A two-entry job queue takes new beats while the back end works or a result waits.
// Reset (synchronous, active low): window length 100, totals and fill count cleared.
// The sample ring is not cleared; a slot is always written before it is read.
module sliding_window_vector_average_unit
    import swva_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_data,
    input  logic             push,
    output logic             full,
    input  t_in_beat         i_data,
    output logic             empty,
    input  logic             pop,
    output t_out_beat        o_result
);

    t_job w_front_job;
    logic w_front_push;
    t_job w_q_job;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;

    swva_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_data     (i_data),
        .i_push     (push),
        .i_q_full   (w_q_full),
        .o_job      (w_front_job),
        .o_job_push (w_front_push)
    );

    swva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_data  (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_job),
        .o_empty (w_q_empty)
    );

    swva_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_job     (w_q_job),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    assign full = w_q_full;

    a_result_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.fill_count != '0))
        else $error("result beat with zero fill count");

    a_result_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((CMP_W + 1)'(o_result.fill_count) <= (CMP_W + 1)'(RING_DEPTH)))
        else $error("fill count beyond ring depth");

    a_job_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_push |-> (w_front_job.count != '0))
        else $error("job queued with zero sample count");

    a_pop_only_when_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("back end took a job from an empty queue");

endmodule

// ----- src/swva_front.sv -----
// Front end: window bookkeeping, slot and fill count assignment per input beat.
module swva_front
    import swva_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WIN_W-1:0]  i_cfg_data,
    input  t_in_beat          i_data,
    input  logic              i_push,
    input  logic              i_q_full,
    output t_job              o_job,
    output logic              o_job_push
);

    logic [WIN_W-1:0]                    r_window;
    logic [SLOT_W-1:0]                   r_slot;
    logic [LEN_W-1:0]                    r_held;
    logic [SLOT_W-1:0]                   n_slot;
    logic [LEN_W-1:0]                    n_held;
    logic [LEN_W-1:0]                    w_len;
    logic [SLOT_W-1:0]                   w_cur_slot;
    logic [LEN_W:0]                      w_next_ext;
    logic                                w_full;
    logic [FIELD_LANES-1:0][SAMPLE_W-1:0] w_in_vec;

    assign w_in_vec = i_data;

    always_comb begin
        priority if (r_window == '0) begin
            w_len = LEN_W'(1);
        end else if (CMP_W'(r_window) > CMP_W'(RING_DEPTH)) begin
            w_len = LEN_W'(RING_DEPTH);
        end else begin
            w_len = LEN_W'(r_window);
        end
    end

    always_comb begin
        w_cur_slot = ((LEN_W + 1)'(r_slot) >= (LEN_W + 1)'(w_len)) ? '0 : r_slot;
        w_full     = (r_held >= w_len);
        w_next_ext = (LEN_W + 1)'(w_cur_slot) + (LEN_W + 1)'(1);
        n_slot     = (w_next_ext >= (LEN_W + 1)'(w_len)) ? '0 : SLOT_W'(w_next_ext);
        n_held     = w_full ? r_held : r_held + LEN_W'(1);
    end

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            o_job.samples[j] = t_sample'(w_in_vec[j]);
        end
        o_job.slot  = w_cur_slot;
        o_job.full  = w_full;
        o_job.count = n_held;
    end

    assign o_job_push = i_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_slot   <= '0;
            r_held   <= '0;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_data;
            r_slot   <= '0;
            r_held   <= '0;
        end else if (o_job_push) begin
            r_slot   <= n_slot;
            r_held   <= n_held;
        end
    end

endmodule

// ----- src/swva_queue.sv -----
// Short job queue between the front end and the back end.
module swva_queue
    import swva_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    assign n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
    assign n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= n_rd_ptr;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/swva_back.sv -----
// Back end: sample ring, running lane totals, bit-serial lane dividers, result register.
module swva_back
    import swva_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_job      i_job,
    input  logic      i_q_empty,
    output logic      o_q_pop,
    output t_out_beat o_result,
    output logic      o_empty,
    input  logic      i_pop
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SUM  = 5'b00100,
        S_PREP = 5'b01000,
        S_DIV  = 5'b10000
    } t_state;

    t_state                       r_state;
    logic                         r_done;
    t_job                         r_job;
    logic [LANES*SAMPLE_W-1:0]    r_ring [RING_DEPTH];
    t_sample [LANES-1:0]          r_rd;
    logic signed [TOT_W-1:0]      r_total [LANES];
    logic [TOT_W-1:0]             r_quo [LANES];
    logic [LEN_W-1:0]             r_rem [LANES];
    logic [LANES-1:0]             r_neg;
    logic [STEP_W-1:0]            r_step;
    t_out_beat                    r_out;
    logic                         r_out_valid;

    logic signed [TOT_W-1:0]      n_total [LANES];
    logic [TOT_W-1:0]             n_quo [LANES];
    logic [LEN_W-1:0]             n_rem [LANES];
    logic [LEN_W:0]               w_shift [LANES];
    logic [FIELD_LANES-1:0][SAMPLE_W-1:0] w_means;
    logic                         w_load_out;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            n_total[j] = r_total[j] + TOT_W'(r_job.samples[j])
                - (r_job.full ? TOT_W'(r_rd[j]) : TOT_W'(0));
            w_shift[j] = {r_rem[j], r_quo[j][TOT_W-1]};
            if (w_shift[j] >= (LEN_W + 1)'(r_job.count)) begin
                n_rem[j] = LEN_W'(w_shift[j] - (LEN_W + 1)'(r_job.count));
                n_quo[j] = {r_quo[j][TOT_W-2:0], 1'b1};
            end else begin
                n_rem[j] = LEN_W'(w_shift[j]);
                n_quo[j] = {r_quo[j][TOT_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        for (int j = 0; j < FIELD_LANES; j++) begin
            if (j < LANES) begin
                w_means[j] = r_neg[j] ? SAMPLE_W'(-r_quo[j]) : SAMPLE_W'(r_quo[j]);
            end else begin
                w_means[j] = '0;
            end
        end
    end

    assign o_q_pop    = (r_state == S_IDLE) && !r_done && !i_q_empty;
    assign w_load_out = r_done && (!r_out_valid || i_pop);
    assign o_result   = r_out;
    assign o_empty    = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            r_ring[r_job.slot] <= r_job.samples;
        end
        r_rd <= r_ring[r_job.slot];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_job;
        end
        if (w_load_out) begin
            r_out <= t_out_beat'({FILL_W'(r_job.count), w_means});
        end
        unique case (r_state)
            S_PREP: begin
                for (int j = 0; j < LANES; j++) begin
                    r_neg[j] <= r_total[j][TOT_W-1];
                    r_quo[j] <= r_total[j][TOT_W-1] ? TOT_W'(-r_total[j])
                                                    : TOT_W'(r_total[j]);
                    r_rem[j] <= '0;
                end
            end
            S_DIV: begin
                for (int j = 0; j < LANES; j++) begin
                    r_quo[j] <= n_quo[j];
                    r_rem[j] <= n_rem[j];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < LANES; j++) begin
                r_total[j] <= '0;
            end
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                for (int j = 0; j < LANES; j++) begin
                    r_total[j] <= '0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_load_out) begin
                        r_done <= 1'b0;
                    end else if (o_q_pop) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    for (int j = 0; j < LANES; j++) begin
                        r_total[j] <= n_total[j];
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(TOT_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sim/swva_mean_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the sliding window vector average unit: window mean prediction and compare.
module swva_mean_checker
    import swva_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_data,
    input  logic             i_push,
    input  logic             i_full,
    input  t_in_beat         i_data,
    input  logic             i_empty,
    input  logic             i_pop,
    input  t_out_beat        i_result,
    output int               o_fail_count,
    output int               o_pending
);

    logic [WIN_W-1:0] window_reg;
    t_sample          history [RING_DEPTH][LANES];
    int               lane_sum [LANES];
    int               next_slot;
    int               held;
    t_out_beat        mean_queue [$];
    int               fail_count = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic clear_history();
        for (int j = 0; j < LANES; j++) begin
            lane_sum[j] = 0;
        end
        next_slot = 0;
        held      = 0;
    endtask

    function automatic t_out_beat window_step(input t_in_beat beat);
        t_sample [LANES-1:0] lane_in;
        t_sample [LANES-1:0] lane_mean;
        int                  span;
        int                  slot;
        logic                wrapped;
        lane_in = beat;
        span = (window_reg == 0) ? 1 : ((window_reg > RING_DEPTH) ? RING_DEPTH : window_reg);
        slot = (next_slot >= span) ? 0 : next_slot;
        wrapped = (held >= span);
        for (int j = 0; j < LANES; j++) begin
            if (wrapped) begin
                lane_sum[j] -= $signed(history[slot][j]);
            end
            history[slot][j] = lane_in[j];
            lane_sum[j] += $signed(lane_in[j]);
        end
        if (!wrapped) begin
            held++;
        end
        slot++;
        next_slot = (slot >= span) ? 0 : slot;
        for (int j = 0; j < LANES; j++) begin
            lane_mean[j] = t_sample'(lane_sum[j] / held);
        end
        return t_out_beat'({FILL_W'(held), lane_mean});
    endfunction

    always @(negedge i_clk) begin : watch_beats
        t_out_beat           want;
        t_sample [LANES-1:0] want_means;
        t_sample [LANES-1:0] got_means;
        if (i_rst_n !== 1'b1) begin
            window_reg = WINDOW_RESET;
            clear_history();
            mean_queue.delete();
        end else begin
            if (i_cfg_we === 1'b1) begin
                window_reg = i_cfg_data;
                clear_history();
            end
            if (i_push === 1'b1 && i_full === 1'b0) begin
                mean_queue = {mean_queue, window_step(i_data)};
            end
            if (i_pop === 1'b1 && i_empty === 1'b0) begin
                if (mean_queue.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing pending: %h", i_result));
                end else begin
                    want       = mean_queue.pop_front();
                    want_means = want[LANES*SAMPLE_W-1:0];
                    got_means  = i_result[LANES*SAMPLE_W-1:0];
                    if (i_result.fill_count !== want.fill_count) begin
                        report_mismatch($sformatf("fill_count expected %0d got %0d",
                                                  want.fill_count, i_result.fill_count));
                    end
                    for (int j = 0; j < LANES; j++) begin
                        if (got_means[j] !== want_means[j]) begin
                            report_mismatch($sformatf("mean_%0d expected %0d got %0d",
                                                      j, $signed(want_means[j]),
                                                      $signed(got_means[j])));
                        end
                    end
                end
            end
        end
        o_pending    = mean_queue.size();
        o_fail_count = fail_count;
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the sliding window vector average unit: stimulus, pacing and verdict.
module tb_top;
    import swva_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PACE_STEP    = 500;
    localparam int STALL_CYCLES = 300;

    typedef enum logic [1:0] {
        PACE_SLOW_DRAIN,
        PACE_SLOW_FEED,
        PACE_FULL_RATE
    } t_pace;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [WIN_W-1:0] i_cfg_data;
    logic             push;
    logic             full;
    t_in_beat         i_data;
    logic             empty;
    logic             pop;
    t_out_beat        o_result;

    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    t_pace            pace        = PACE_SLOW_DRAIN;
    bit               stall_req   = 1'b0;
    bit               stall_done  = 1'b0;

    sliding_window_vector_average_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_data     (i_data),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    swva_mean_checker u_mean_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_data       (i_data),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sliding_window_vector_average_unit verification failed");
            $finish;
        end
    end

    function automatic int idle_percent(input t_pace p, input bit on_receiver);
        case (p)
            PACE_SLOW_DRAIN: return on_receiver ? 82 : 36;
            PACE_SLOW_FEED:  return on_receiver ? 36 : 82;
            default:         return 0;
        endcase
    endfunction

    function automatic t_in_beat same_lanes(input t_sample v);
        return t_in_beat'({LANES{v}});
    endfunction

    function automatic t_in_beat random_vector();
        t_sample [LANES-1:0] v;
        int                  pick;
        for (int j = 0; j < LANES; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                v[j] = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            end else if (pick < 30) begin
                v[j] = t_sample'($urandom_range(0, 8) - 4);
            end else begin
                v[j] = t_sample'($urandom);
            end
        end
        return t_in_beat'(v);
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return WIN_W'($urandom_range(1, 8));
        if (pick < 65) return WIN_W'($urandom_range(9, 40));
        if (pick < 75) return WIN_W'($urandom_range(100, RING_DEPTH));
        if (pick < 80) return '0;
        if (pick < 88) return WIN_W'($urandom_range(RING_DEPTH + 1, 255));
        return (pick < 94) ? WIN_W'(1) : WIN_W'(255);
    endfunction

    task automatic send_vector(input t_in_beat beat);
        int   idle_pct;
        logic taken;
        idle_pct = idle_percent(pace, 1'b0);
        if ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        push   <= 1'b1;
        i_data <= beat;
        do begin
            @(negedge i_clk);
            taken = (full === 1'b0);
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] len);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : receiver
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req && !stall_done) begin
                // hold off pop so the job queue fills and full rises
                pop <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
                stall_done = 1'b1;
            end else begin
                pop <= ($urandom_range(0, 99) >= idle_percent(pace, 1'b1));
            end
        end
    end

    initial begin : stimulus
        int               random_sent;
        int               span;
        int               beats;
        logic [WIN_W-1:0] win;
        random_sent = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        push       <= 1'b0;
        i_data     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window length, field extremes
        send_vector(same_lanes(16'sh7fff));
        send_vector(same_lanes(16'sh8000));
        send_vector(same_lanes(16'sh0000));
        send_vector(same_lanes(16'shffff));
        send_vector(t_in_beat'({(LANES / 2){16'sh7fff, 16'sh8000}}));
        send_vector(random_vector());

        // zero length acts as one
        write_window('0);
        send_vector(same_lanes(16'sh7fff));
        send_vector(same_lanes(16'sh8000));
        send_vector(same_lanes(16'shffff));

        // negative means truncate toward zero
        write_window(WIN_W'(2));
        send_vector(same_lanes(-16'sd1));
        send_vector(same_lanes(-16'sd2));
        send_vector(same_lanes(16'sd3));
        send_vector(same_lanes(-16'sd8));

        // length above the ring saturates
        write_window(WIN_W'(255));
        send_vector(same_lanes(16'sh8000));
        send_vector(same_lanes(16'sh8000));
        send_vector(same_lanes(16'sh7fff));

        write_window(WIN_W'(1));
        send_vector(same_lanes(16'sh8000));
        send_vector(random_vector());

        write_window(WIN_W'(RING_DEPTH));
        send_vector(same_lanes(16'sh7fff));
        send_vector(same_lanes(16'sh7fff));

        while (random_sent < RANDOM_ITEMS) begin
            win = pick_window();
            write_window(win);
            span  = (win == 0) ? 1 : ((win > RING_DEPTH) ? RING_DEPTH : win);
            beats = span + $urandom_range(1, span + 8);
            if (random_sent >= 2 * PACE_STEP && !stall_req) begin
                stall_req = 1'b1;
                if (beats < 24) beats = 24;
            end
            repeat (beats) begin
                pace = (random_sent < PACE_STEP)     ? PACE_SLOW_DRAIN :
                       (random_sent < 2 * PACE_STEP) ? PACE_SLOW_FEED  : PACE_FULL_RATE;
                send_vector(random_vector());
                random_sent++;
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sliding_window_vector_average_unit verification clean");
        end else begin
            $display("sliding_window_vector_average_unit verification failed");
        end
        $finish;
    end

endmodule
